// ===== rtl/tbc_pkg.sv =====
`default_nettype none
package tbc_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int WEIGHT_FRAC_DEF = 14;
	localparam int WEIGHT_W        = 16;
	localparam int CFG_AW          = 2;
	localparam int CFG_DW          = 32;
	localparam int TOL_W           = 14;
	localparam int NUM_AREAS       = 4;
	localparam int NUM_PARTS       = 3;

	localparam logic [CFG_DW-1:0] SEAM_RST = 32'd0;
	localparam logic [CFG_DW-1:0] AREA_RST = 32'd1;
	localparam logic [TOL_W-1:0]  TOL_RST  = 14'd3;

	// corner indices into the point list: 0..3 corners one..four, 4 query point
	// area 0 is the whole triangle, areas 1..3 are opposite corners one, two, four
	localparam int AREA_O [NUM_AREAS] = '{0, 4, 4, 4};
	localparam int AREA_A [NUM_AREAS] = '{1, 1, 0, 1};
	localparam int AREA_B [NUM_AREAS] = '{3, 3, 3, 0};

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOT_TRI = 2'd1,
		ST_DEGEN   = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_SEAM     = 2'd0,
		REG_MIN_AREA = 2'd1,
		REG_TOL      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic seam_bad;
		logic degen;
	} tbc_flags_t;

	function automatic int max_of(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tbc_if.sv =====
`default_nettype none
interface tbc_item_if import tbc_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
);
	logic            valid;
	logic            ready;
	logic [3*CW-1:0] corner_one;
	logic [3*CW-1:0] corner_two;
	logic [3*CW-1:0] corner_three;
	logic [3*CW-1:0] corner_four;
	logic [3*CW-1:0] query_point;

	modport source (output valid, corner_one, corner_two, corner_three, corner_four,
		query_point, input ready);
	modport sink (input valid, corner_one, corner_two, corner_three, corner_four,
		query_point, output ready);
endinterface

interface tbc_result_if import tbc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] weight_one;
	logic [WEIGHT_W-1:0] weight_two;
	logic [WEIGHT_W-1:0] weight_four;
	status_t             status;

	modport source (output valid, weight_one, weight_two, weight_four, status, input ready);
	modport sink (input valid, weight_one, weight_two, weight_four, status, output ready);
endinterface

interface tbc_cfg_if import tbc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tbc_sqrt_cell.sv =====
`default_nettype none
// One digit of a restoring square root for every lane: two radicand bits in,
// one root bit out.
module tbc_sqrt_cell import tbc_pkg::*; #(
	parameter int LANES = NUM_AREAS,
	parameter int SW    = 70,
	parameter int RW    = 38,
	parameter int AW    = 35
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire tbc_flags_t                  in_flags,
	input  wire logic [LANES-1:0][SW-1:0]    in_rad,
	input  wire logic [LANES-1:0][RW-1:0]    in_rem,
	input  wire logic [LANES-1:0][AW-1:0]    in_root,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tbc_flags_t                       out_flags,
	output logic [LANES-1:0][SW-1:0]         out_rad,
	output logic [LANES-1:0][RW-1:0]         out_rem,
	output logic [LANES-1:0][AW-1:0]         out_root
);

	logic                      v_q;
	logic [LANES-1:0][RW-1:0]  t_rem;
	logic [LANES-1:0][RW-1:0]  trial;
	logic [LANES-1:0]          ge;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			t_rem[l] = {in_rem[l][RW-3:0], in_rad[l][SW-1:SW-2]};
			trial[l] = RW'({in_root[l], 2'b01});
			ge[l]    = t_rem[l] >= trial[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_flags <= in_flags;
			for (int l = 0; l < LANES; l++) begin
				out_rad[l]  <= {in_rad[l][SW-3:0], 2'b00};
				out_rem[l]  <= ge[l] ? (t_rem[l] - trial[l]) : t_rem[l];
				out_root[l] <= {in_root[l][AW-2:0], ge[l]};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbc_div_cell.sv =====
`default_nettype none
// One quotient bit of a restoring division for every lane, shared divisor.
module tbc_div_cell import tbc_pkg::*; #(
	parameter int LANES = NUM_PARTS,
	parameter int AW    = 35
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire tbc_flags_t                   in_flags,
	input  wire logic [AW-1:0]                in_whole,
	input  wire logic [LANES-1:0]             in_sat,
	input  wire logic [LANES-1:0][AW:0]       in_rem,
	input  wire logic [LANES-1:0][WEIGHT_W-1:0] in_lo,
	input  wire logic [LANES-1:0][WEIGHT_W-1:0] in_quo,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output tbc_flags_t                        out_flags,
	output logic [AW-1:0]                     out_whole,
	output logic [LANES-1:0]                  out_sat,
	output logic [LANES-1:0][AW:0]            out_rem,
	output logic [LANES-1:0][WEIGHT_W-1:0]    out_lo,
	output logic [LANES-1:0][WEIGHT_W-1:0]    out_quo
);

	logic                      v_q;
	logic [LANES-1:0][AW+1:0]  t_rem;
	logic [LANES-1:0][AW+1:0]  n_rem;
	logic [LANES-1:0]          ge;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			t_rem[l] = {in_rem[l], in_lo[l][WEIGHT_W-1]};
			ge[l]    = t_rem[l] >= (AW+2)'(in_whole);
			n_rem[l] = ge[l] ? (t_rem[l] - (AW+2)'(in_whole)) : t_rem[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_flags <= in_flags;
			out_whole <= in_whole;
			out_sat   <= in_sat;
			for (int l = 0; l < LANES; l++) begin
				out_rem[l] <= n_rem[l][AW:0];
				out_lo[l]  <= {in_lo[l][WEIGHT_W-2:0], 1'b0};
				out_quo[l] <= {in_quo[l][WEIGHT_W-2:0], ge[l]};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/triangle_barycentric_coords.sv =====
// Channel | Dir | Beat carries
// req     | in  | corner_one..corner_four, query_point (3 signed coords each)
// rsp     | out | weight_one, weight_two, weight_four, status
// cfg     | in  | addr (register index), data; always ready
//
// One item per cycle sustained while rsp is ready.
// The root cell chain (one root bit per cell) and the 16-cell quotient chain
// follow six front stages of multiply and add.
// Reset clears only stage valid bits and the registers; no clearing pass.
// Each stage moves when its successor is empty or moving, so bubbles close up
// and rsp stalls back up only as far as the chain is full.
`default_nettype none
module triangle_barycentric_coords import tbc_pkg::*; #(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tbc_item_if.sink  req,
	tbc_result_if.source rsp,
	tbc_cfg_if.sink   cfg
);

	localparam int CW    = COORD_WIDTH;
	localparam int WF    = WEIGHT_FRAC_BITS;
	localparam int DW    = CW + 1;
	localparam int MW    = 2 * DW;
	localparam int AW    = MW + 1;
	localparam int SW    = 2 * AW;
	localparam int RW    = AW + 3;
	localparam int SMW   = 2 * DW + 2;
	localparam int NW    = AW + WF + WEIGHT_W;
	localparam int CMPW  = max_of(AW, CFG_DW);
	localparam int SCMPW = max_of(SMW, CFG_DW);
	localparam int SUMW  = max_of(WEIGHT_W + 2, WF + 2);

	// registers
	logic [CFG_DW-1:0] seam_lim_q;
	logic [CFG_DW-1:0] min_area_q;
	logic [TOL_W-1:0]  tol_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seam_lim_q <= SEAM_RST;
			min_area_q <= AREA_RST;
			tol_q      <= TOL_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				REG_SEAM:     seam_lim_q <= cfg.data;
				REG_MIN_AREA: min_area_q <= cfg.data;
				REG_TOL:      tol_q      <= cfg.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// front stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
	logic sq_rdy0, dv_rdy0, adv_o;

	assign adv7 = !v_s7 || dv_rdy0;
	assign adv6 = !v_s6 || sq_rdy0;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign req.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// unpack
	logic signed [CW-1:0] pt [5][3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pt[0][c] = req.corner_one[c*CW +: CW];
			pt[1][c] = req.corner_two[c*CW +: CW];
			pt[2][c] = req.corner_three[c*CW +: CW];
			pt[3][c] = req.corner_four[c*CW +: CW];
			pt[4][c] = req.query_point[c*CW +: CW];
		end
	end

	// s1: edge vectors
	logic signed [DW-1:0] va_s1 [NUM_AREAS][3];
	logic signed [DW-1:0] vb_s1 [NUM_AREAS][3];
	logic signed [DW-1:0] sd_s1 [3];

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				for (int c = 0; c < 3; c++) begin
					va_s1[ar][c] <= DW'(pt[AREA_A[ar]][c]) - DW'(pt[AREA_O[ar]][c]);
					vb_s1[ar][c] <= DW'(pt[AREA_B[ar]][c]) - DW'(pt[AREA_O[ar]][c]);
				end
			end
			for (int c = 0; c < 3; c++) begin
				sd_s1[c] <= DW'(pt[1][c]) - DW'(pt[2][c]);
			end
		end
	end

	// s2: cross product terms, seam squares
	logic signed [MW-1:0] pp_s2 [NUM_AREAS][3];
	logic signed [MW-1:0] pn_s2 [NUM_AREAS][3];
	logic signed [MW-1:0] ssq_s2 [3];

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s2[ar][c] <= MW'(va_s1[ar][(c+1)%3]) * MW'(vb_s1[ar][(c+2)%3]);
					pn_s2[ar][c] <= MW'(va_s1[ar][(c+2)%3]) * MW'(vb_s1[ar][(c+1)%3]);
				end
			end
			for (int c = 0; c < 3; c++) begin
				ssq_s2[c] <= MW'(sd_s1[c]) * MW'(sd_s1[c]);
			end
		end
	end

	// s3: cross components as magnitudes, seam check
	logic signed [MW:0] cr [NUM_AREAS][3];
	logic [SMW-1:0]     seam;
	logic [MW-1:0]      mag_s3 [NUM_AREAS][3];
	logic               seam_bad_s3;

	always_comb begin
		for (int ar = 0; ar < NUM_AREAS; ar++) begin
			for (int c = 0; c < 3; c++) begin
				cr[ar][c] = (MW+1)'(pp_s2[ar][c]) - (MW+1)'(pn_s2[ar][c]);
			end
		end
		seam = SMW'(unsigned'(ssq_s2[0])) + SMW'(unsigned'(ssq_s2[1]))
			+ SMW'(unsigned'(ssq_s2[2]));
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				for (int c = 0; c < 3; c++) begin
					mag_s3[ar][c] <= cr[ar][c][MW] ? MW'(-cr[ar][c]) : MW'(cr[ar][c]);
				end
			end
			seam_bad_s3 <= SCMPW'(seam) > SCMPW'(seam_lim_q);
		end
	end

	// s4: split squares into half-width partial products
	logic [MW-1:0] hh_s4 [NUM_AREAS][3];
	logic [MW-1:0] hl_s4 [NUM_AREAS][3];
	logic [MW-1:0] ll_s4 [NUM_AREAS][3];
	logic          seam_bad_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				for (int c = 0; c < 3; c++) begin
					hh_s4[ar][c] <= MW'(mag_s3[ar][c][MW-1:DW]) * MW'(mag_s3[ar][c][MW-1:DW]);
					hl_s4[ar][c] <= MW'(mag_s3[ar][c][MW-1:DW]) * MW'(mag_s3[ar][c][DW-1:0]);
					ll_s4[ar][c] <= MW'(mag_s3[ar][c][DW-1:0]) * MW'(mag_s3[ar][c][DW-1:0]);
				end
			end
			seam_bad_s4 <= seam_bad_s3;
		end
	end

	// s5: component squares
	logic [SW-1:0] csq_s5 [NUM_AREAS][3];
	logic          seam_bad_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				for (int c = 0; c < 3; c++) begin
					csq_s5[ar][c] <= (SW'(hh_s4[ar][c]) << MW) + (SW'(hl_s4[ar][c]) << (DW + 1))
						+ SW'(ll_s4[ar][c]);
				end
			end
			seam_bad_s5 <= seam_bad_s4;
		end
	end

	// s6: squared doubled areas
	logic [NUM_AREAS-1:0][SW-1:0] sum_s6;
	logic                         seam_bad_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			for (int ar = 0; ar < NUM_AREAS; ar++) begin
				sum_s6[ar] <= csq_s5[ar][0] + csq_s5[ar][1] + csq_s5[ar][2];
			end
			seam_bad_s6 <= seam_bad_s5;
		end
	end

	// square root cell chain
	logic                          sq_v    [AW+1];
	logic                          sq_r    [AW+1];
	tbc_flags_t                    sq_f    [AW+1];
	logic [NUM_AREAS-1:0][SW-1:0]  sq_rad  [AW+1];
	logic [NUM_AREAS-1:0][RW-1:0]  sq_rem  [AW+1];
	logic [NUM_AREAS-1:0][AW-1:0]  sq_root [AW+1];

	assign sq_v[0]    = v_s6;
	assign sq_f[0]    = '{seam_bad: seam_bad_s6, degen: 1'b0};
	assign sq_rad[0]  = sum_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rdy0    = sq_r[0];
	assign sq_r[AW]   = adv7;

	for (genvar k = 0; k < AW; k++) begin : g_sqrt
		tbc_sqrt_cell #(
			.LANES(NUM_AREAS),
			.SW   (SW),
			.RW   (RW),
			.AW   (AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[k]),
			.in_ready (sq_r[k]),
			.in_flags (sq_f[k]),
			.in_rad   (sq_rad[k]),
			.in_rem   (sq_rem[k]),
			.in_root  (sq_root[k]),
			.out_valid(sq_v[k+1]),
			.out_ready(sq_r[k+1]),
			.out_flags(sq_f[k+1]),
			.out_rad  (sq_rad[k+1]),
			.out_rem  (sq_rem[k+1]),
			.out_root (sq_root[k+1])
		);
	end

	// s7: degenerate check, saturation check, divider setup
	logic [AW-1:0]                          whole;
	logic [NUM_PARTS-1:0][NW-1:0]           nfull;
	logic                                   degen;
	logic [AW-1:0]                          whole_s7;
	tbc_flags_t                             flags_s7;
	logic [NUM_PARTS-1:0]                   sat_s7;
	logic [NUM_PARTS-1:0][AW:0]             rem_s7;
	logic [NUM_PARTS-1:0][WEIGHT_W-1:0]     lo_s7;

	assign whole = sq_root[AW][0];
	assign degen = (whole == '0) || (CMPW'(whole) < CMPW'(min_area_q));

	always_comb begin
		for (int l = 0; l < NUM_PARTS; l++) begin
			nfull[l] = NW'(sq_root[AW][l+1]) << WF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv7) begin
			v_s7 <= sq_v[AW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			whole_s7 <= whole;
			flags_s7 <= '{seam_bad: sq_f[AW].seam_bad, degen: degen};
			for (int l = 0; l < NUM_PARTS; l++) begin
				// quotient needs more than WEIGHT_W bits: clamp
				sat_s7[l] <= nfull[l] >= (NW'(whole) << WEIGHT_W);
				rem_s7[l] <= nfull[l][WEIGHT_W +: AW+1];
				lo_s7[l]  <= nfull[l][WEIGHT_W-1:0];
			end
		end
	end

	// divider cell chain
	logic                               dv_v     [WEIGHT_W+1];
	logic                               dv_r     [WEIGHT_W+1];
	tbc_flags_t                         dv_f     [WEIGHT_W+1];
	logic [AW-1:0]                      dv_whole [WEIGHT_W+1];
	logic [NUM_PARTS-1:0]               dv_sat   [WEIGHT_W+1];
	logic [NUM_PARTS-1:0][AW:0]         dv_rem   [WEIGHT_W+1];
	logic [NUM_PARTS-1:0][WEIGHT_W-1:0] dv_lo    [WEIGHT_W+1];
	logic [NUM_PARTS-1:0][WEIGHT_W-1:0] dv_quo   [WEIGHT_W+1];

	assign dv_v[0]        = v_s7;
	assign dv_f[0]        = flags_s7;
	assign dv_whole[0]    = whole_s7;
	assign dv_sat[0]      = sat_s7;
	assign dv_rem[0]      = rem_s7;
	assign dv_lo[0]       = lo_s7;
	assign dv_quo[0]      = '0;
	assign dv_rdy0        = dv_r[0];
	assign dv_r[WEIGHT_W] = adv_o;

	for (genvar k = 0; k < WEIGHT_W; k++) begin : g_div
		tbc_div_cell #(
			.LANES(NUM_PARTS),
			.AW   (AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[k]),
			.in_ready (dv_r[k]),
			.in_flags (dv_f[k]),
			.in_whole (dv_whole[k]),
			.in_sat   (dv_sat[k]),
			.in_rem   (dv_rem[k]),
			.in_lo    (dv_lo[k]),
			.in_quo   (dv_quo[k]),
			.out_valid(dv_v[k+1]),
			.out_ready(dv_r[k+1]),
			.out_flags(dv_f[k+1]),
			.out_whole(dv_whole[k+1]),
			.out_sat  (dv_sat[k+1]),
			.out_rem  (dv_rem[k+1]),
			.out_lo   (dv_lo[k+1]),
			.out_quo  (dv_quo[k+1])
		);
	end

	// output register
	logic [NUM_PARTS-1:0][WEIGHT_W-1:0] wt;
	logic [SUMW-1:0]                    wsum;
	logic [SUMW-1:0]                    dev;
	logic                               ov_q;
	tbc_flags_t                         fin;

	assign fin   = dv_f[WEIGHT_W];
	assign adv_o = !ov_q || rsp.ready;
	assign rsp.valid = ov_q;

	always_comb begin
		for (int l = 0; l < NUM_PARTS; l++) begin
			wt[l] = dv_sat[WEIGHT_W][l] ? '1 : dv_quo[WEIGHT_W][l];
		end
		wsum = SUMW'(wt[0]) + SUMW'(wt[1]) + SUMW'(wt[2]);
		dev  = (wsum > (SUMW'(1) << WF)) ? (wsum - (SUMW'(1) << WF))
			: ((SUMW'(1) << WF) - wsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv_o) begin
			ov_q <= dv_v[WEIGHT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			if (fin.seam_bad || fin.degen) begin
				rsp.weight_one  <= '0;
				rsp.weight_two  <= '0;
				rsp.weight_four <= '0;
				rsp.status      <= fin.seam_bad ? ST_NOT_TRI : ST_DEGEN;
			end else begin
				rsp.weight_one  <= wt[0];
				rsp.weight_two  <= wt[1];
				rsp.weight_four <= wt[2];
				rsp.status      <= (dev > SUMW'(tol_q)) ? ST_OUTSIDE : ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbc_checker.sv =====
`default_nettype none
module tbc_checker import tbc_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [WEIGHT_W-1:0] rsp_w1,
	input wire logic [WEIGHT_W-1:0] rsp_w2,
	input wire logic [WEIGHT_W-1:0] rsp_w4,
	input wire status_t             rsp_status,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_w1, rsp_w2, rsp_w4, rsp_status}))
		else $error("rsp beat changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NOT_TRI || rsp_status == ST_DEGEN)
			|-> rsp_w1 == '0 && rsp_w2 == '0 && rsp_w4 == '0)
		else $error("rejected item carries weights");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("req stalled while rsp drains");

	a_cfg_take: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write not taken");

endmodule

bind triangle_barycentric_coords tbc_checker u_tbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_w1    (rsp.weight_one),
	.rsp_w2    (rsp.weight_two),
	.rsp_w4    (rsp.weight_four),
	.rsp_status(rsp.status),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
`default_nettype wire
